// ===== hdl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Holds the item structs, status and operation codes, and the memory port structs.
// Depends on nothing; every other file imports it.
package ffha_pkg;

	// Arena geometry.
	localparam int GRAN_BYTES     = 8;
	localparam int GRAN_SHIFT     = $clog2(GRAN_BYTES);
	localparam int HDR_BYTES      = 16;
	localparam int PAGE_BYTES     = 4096;
	localparam int PAGE_BYTE_SHIFT = $clog2(PAGE_BYTES);
	localparam int MAX_PAGES      = 16;
	localparam int PAGE_GRANULES  = PAGE_BYTES / GRAN_BYTES;
	localparam int PAGE_SHIFT     = $clog2(PAGE_GRANULES);
	localparam int ARENA_GRANULES = MAX_PAGES * PAGE_GRANULES;
	localparam int IDX_W          = $clog2(ARENA_GRANULES);
	localparam int SIZE_W         = IDX_W + 1;
	localparam int MIN_GRANULES   = (HDR_BYTES + 2 * GRAN_BYTES - 1) / GRAN_BYTES;
	localparam int INIT_PAGES     = 4;
	localparam int PG_W           = 5;
	localparam int NEED_W         = 33 - GRAN_SHIFT;
	localparam int PAGES_W        = NEED_W - PAGE_SHIFT + 1;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_OOM     = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_LIMIT = 1'b0;
	localparam logic CFG_GROW  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] request_bytes;
		logic [15:0] block_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] data_address;
		logic [16:0] mapped_bytes;
		logic [16:0] used_bytes;
	} rsp_t;

	// Block store access: one read address, one write to each memory.
	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
		logic              a_we;
		logic [IDX_W-1:0]  a_addr;
		logic [SIZE_W-1:0] a_size;
		logic              a_free;
		logic              b_we;
		logic [IDX_W-1:0]  b_addr;
		logic [IDX_W-1:0]  b_prev;
	} store_cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              free;
		logic [IDX_W-1:0]  prev;
	} store_rd_t;

endpackage

// ===== hdl/ffha_store.sv =====
// Block store: size/free memory and previous-block memory, one entry per granule.
// Synchronous memories with a registered read; read data is valid in the cycle after rd_en.
// Depends on ffha_pkg.
module ffha_store import ffha_pkg::*; (
	input  logic       clk,
	input  store_cmd_t cmd,
	output store_rd_t  rd
);

	logic [SIZE_W:0]   mem_a [ARENA_GRANULES];
	logic [IDX_W-1:0]  mem_b [ARENA_GRANULES];
	logic [SIZE_W:0]   rd_a_q;
	logic [IDX_W-1:0]  rd_b_q;

	// Size and free flag of the block starting at each granule.
	always_ff @(posedge clk) begin
		if (cmd.a_we) begin
			mem_a[cmd.a_addr] <= {cmd.a_size, cmd.a_free};
		end
		if (cmd.rd_en) begin
			rd_a_q <= mem_a[cmd.rd_addr];
		end
	end

	// Start granule of the preceding block.
	always_ff @(posedge clk) begin
		if (cmd.b_we) begin
			mem_b[cmd.b_addr] <= cmd.b_prev;
		end
		if (cmd.rd_en) begin
			rd_b_q <= mem_b[cmd.rd_addr];
		end
	end

	assign rd.size = rd_a_q[SIZE_W:1];
	assign rd.free = rd_a_q[0];
	assign rd.prev = rd_b_q;

endmodule

// ===== hdl/ffha_ctrl.sv =====
// Allocator sequencer: clearing pass, first-fit walk, arena growth, free with merging.
// Drives the block store through read-modify-write steps, one access per memory a cycle.
// Depends on ffha_pkg.
module ffha_ctrl import ffha_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  req_t            item,
	input  logic [PG_W-1:0] limit_pages,
	input  logic [PG_W-1:0] grow_pages,
	input  logic            res_ready,
	output logic            idle,
	output logic            done,
	output rsp_t            result,
	output store_cmd_t      cmd,
	input  store_rd_t       rd
);

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] W_RD    = 5'd2;
	localparam logic [4:0] W_CHK   = 5'd3;
	localparam logic [4:0] W_SPL   = 5'd4;
	localparam logic [4:0] G_CALC  = 5'd5;
	localparam logic [4:0] G_CHK   = 5'd6;
	localparam logic [4:0] F_RD    = 5'd7;
	localparam logic [4:0] F_CHK   = 5'd8;
	localparam logic [4:0] F_NRD   = 5'd9;
	localparam logic [4:0] F_NCHK  = 5'd10;
	localparam logic [4:0] F_NN    = 5'd11;
	localparam logic [4:0] F_PRV   = 5'd12;
	localparam logic [4:0] F_PCHK  = 5'd13;
	localparam logic [4:0] F_PM2   = 5'd14;
	localparam logic [4:0] F_PM3   = 5'd15;
	localparam logic [4:0] F_SELF  = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(INIT_PAGES * PAGE_GRANULES);

	logic [4:0]         state_q, state_d;
	logic [IDX_W-1:0]   clr_q, clr_d;
	logic [NEED_W-1:0]  need_q, need_d;
	logic [SIZE_W-1:0]  walk_q, walk_d;
	logic [IDX_W-1:0]   last_q, last_d;
	logic [SIZE_W-1:0]  last_size_q, last_size_d;
	logic               last_free_q, last_free_d;
	logic [SIZE_W-1:0]  cur_size_q, cur_size_d;
	logic [IDX_W-1:0]   cur_prev_q, cur_prev_d;
	logic [SIZE_W-1:0]  other_q, other_d;
	logic [SIZE_W-1:0]  nn_q, nn_d;
	logic [PAGES_W-1:0] pages_q, pages_d;
	logic               tries_q, tries_d;
	logic [1:0]         status_q, status_d;
	logic [15:0]        addr_q, addr_d;
	logic [PG_W-1:0]    mapped_q, mapped_d;
	logic [16:0]        used_q, used_d;

	logic [SIZE_W-1:0]  end_g;
	logic [32:0]        need_sum;
	logic [NEED_W-1:0]  need_raw;
	logic [15:0]        free_off;
	logic [16:0]        free_g;
	logic [NEED_W:0]    pneed_sum;
	logic [PAGES_W-1:0] pneed;
	logic [PG_W-1:0]    limit_eff;
	logic [SIZE_W-1:0]  gsize;
	logic [SIZE_W-1:0]  sum_a;
	logic [SIZE_W-1:0]  sum_b;

	// Arena end in granules and request size arithmetic.
	assign end_g     = SIZE_W'(mapped_q) << PAGE_SHIFT;
	assign need_sum  = {1'b0, item.request_bytes} + 33'(HDR_BYTES + GRAN_BYTES - 1);
	assign need_raw  = need_sum[32:GRAN_SHIFT];
	assign free_off  = item.block_address - 16'(HDR_BYTES);
	assign free_g    = 17'(free_off >> GRAN_SHIFT);
	assign pneed_sum = {1'b0, need_q} + (NEED_W + 1)'(PAGE_GRANULES - 1);
	assign pneed     = pneed_sum[NEED_W:PAGE_SHIFT];
	assign limit_eff = (limit_pages < PG_W'(MAX_PAGES)) ? limit_pages : PG_W'(MAX_PAGES);
	assign gsize     = SIZE_W'(pages_q) << PAGE_SHIFT;
	assign sum_a     = walk_q + cur_size_q;
	assign sum_b     = rd.size + cur_size_q;

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE) && res_ready;
	assign result.status       = status_q;
	assign result.data_address = addr_q;
	assign result.mapped_bytes = 17'(mapped_q) << PAGE_BYTE_SHIFT;
	assign result.used_bytes   = used_q;

	// Next state and store accesses.
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		need_d      = need_q;
		walk_d      = walk_q;
		last_d      = last_q;
		last_size_d = last_size_q;
		last_free_d = last_free_q;
		cur_size_d  = cur_size_q;
		cur_prev_d  = cur_prev_q;
		other_d     = other_q;
		nn_d        = nn_q;
		pages_d     = pages_q;
		tries_d     = tries_q;
		status_d    = status_q;
		addr_d      = addr_q;
		mapped_d    = mapped_q;
		used_d      = used_q;
		cmd         = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.a_we   = 1'b1;
				cmd.a_addr = clr_q;
				cmd.a_size = (clr_q == '0) ? INIT_SIZE : '0;
				cmd.a_free = (clr_q == '0);
				cmd.b_we   = 1'b1;
				cmd.b_addr = clr_q;
				clr_d      = clr_q + 1'b1;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					status_d = ST_OK;
					addr_d   = '0;
					if (item.operation == OP_ALLOC) begin
						if (item.request_bytes == '0) begin
							status_d = ST_NULL;
							state_d  = S_DONE;
						end else begin
							need_d  = (need_raw < NEED_W'(MIN_GRANULES)) ?
								NEED_W'(MIN_GRANULES) : need_raw;
							walk_d  = '0;
							last_d  = '0;
							tries_d = 1'b0;
							state_d = W_RD;
						end
					end else begin
						if (item.block_address == '0) begin
							status_d = ST_NULL;
							state_d  = S_DONE;
						end else if (item.block_address < 16'(HDR_BYTES) ||
								free_off[GRAN_SHIFT-1:0] != '0 ||
								free_g >= 17'(end_g)) begin
							status_d = ST_BADFREE;
							state_d  = S_DONE;
						end else begin
							walk_d  = SIZE_W'(free_g);
							state_d = F_RD;
						end
					end
				end
			end
			// First-fit walk: read a block header, then test it.
			W_RD: begin
				if (walk_q < end_g) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = walk_q[IDX_W-1:0];
					state_d     = W_CHK;
				end else begin
					state_d = G_CALC;
				end
			end
			W_CHK: begin
				if (rd.size == '0) begin
					state_d = G_CALC;
				end else if (rd.free && NEED_W'(rd.size) >= need_q) begin
					status_d = ST_OK;
					addr_d   = 16'((32'(walk_q) << GRAN_SHIFT) + 32'(HDR_BYTES));
					if (NEED_W'(rd.size) < need_q + NEED_W'(MIN_GRANULES)) begin
						cmd.a_we   = 1'b1;
						cmd.a_addr = walk_q[IDX_W-1:0];
						cmd.a_size = rd.size;
						used_d     = used_q + (17'(rd.size) << GRAN_SHIFT);
						state_d    = S_DONE;
					end else begin
						// Split: the remainder becomes a new free block.
						other_d    = walk_q + need_q[SIZE_W-1:0];
						cmd.a_we   = 1'b1;
						cmd.a_addr = IDX_W'(walk_q + need_q[SIZE_W-1:0]);
						cmd.a_size = rd.size - need_q[SIZE_W-1:0];
						cmd.a_free = 1'b1;
						cmd.b_we   = 1'b1;
						cmd.b_addr = IDX_W'(walk_q + need_q[SIZE_W-1:0]);
						cmd.b_prev = walk_q[IDX_W-1:0];
						cur_size_d = rd.size;
						state_d    = W_SPL;
					end
				end else begin
					last_d      = walk_q[IDX_W-1:0];
					last_size_d = rd.size;
					last_free_d = rd.free;
					walk_d      = walk_q + rd.size;
					state_d     = W_RD;
				end
			end
			W_SPL: begin
				cmd.a_we   = 1'b1;
				cmd.a_addr = walk_q[IDX_W-1:0];
				cmd.a_size = need_q[SIZE_W-1:0];
				if (sum_a < end_g) begin
					cmd.b_we   = 1'b1;
					cmd.b_addr = sum_a[IDX_W-1:0];
					cmd.b_prev = other_q[IDX_W-1:0];
				end
				used_d  = used_q + (17'(need_q[SIZE_W-1:0]) << GRAN_SHIFT);
				state_d = S_DONE;
			end
			// Arena growth by whole pages.
			G_CALC: begin
				pages_d = (pneed < PAGES_W'(grow_pages)) ? PAGES_W'(grow_pages) : pneed;
				state_d = G_CHK;
			end
			G_CHK: begin
				if (pages_q == '0 ||
						(PAGES_W + 1)'(mapped_q) + (PAGES_W + 1)'(pages_q) >
						(PAGES_W + 1)'(limit_eff)) begin
					status_d = ST_OOM;
					state_d  = S_DONE;
				end else begin
					cmd.a_we   = 1'b1;
					cmd.a_free = 1'b1;
					if (last_free_q) begin
						cmd.a_addr = last_q;
						cmd.a_size = last_size_q + gsize;
					end else begin
						cmd.a_addr = end_g[IDX_W-1:0];
						cmd.a_size = gsize;
						cmd.b_we   = 1'b1;
						cmd.b_addr = end_g[IDX_W-1:0];
						cmd.b_prev = last_q;
					end
					mapped_d = mapped_q + pages_q[PG_W-1:0];
					if (tries_q) begin
						status_d = ST_OOM;
						state_d  = S_DONE;
					end else begin
						tries_d = 1'b1;
						walk_d  = '0;
						last_d  = '0;
						state_d = W_RD;
					end
				end
			end
			// Free: check the block, then merge with the next and previous blocks.
			F_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = walk_q[IDX_W-1:0];
				state_d     = F_CHK;
			end
			F_CHK: begin
				if (rd.size == '0 || rd.free) begin
					status_d = ST_BADFREE;
					state_d  = S_DONE;
				end else begin
					cur_size_d = rd.size;
					cur_prev_d = rd.prev;
					used_d     = used_q - (17'(rd.size) << GRAN_SHIFT);
					other_d    = walk_q + rd.size;
					state_d    = F_NRD;
				end
			end
			F_NRD: begin
				if (other_q < end_g) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = other_q[IDX_W-1:0];
					state_d     = F_NCHK;
				end else begin
					state_d = F_PRV;
				end
			end
			F_NCHK: begin
				if (rd.free) begin
					cur_size_d = sum_b;
					cmd.a_we   = 1'b1;
					cmd.a_addr = other_q[IDX_W-1:0];
					cmd.b_we   = 1'b1;
					cmd.b_addr = other_q[IDX_W-1:0];
					state_d    = F_NN;
				end else begin
					state_d = F_PRV;
				end
			end
			F_NN: begin
				if (sum_a < end_g) begin
					cmd.b_we   = 1'b1;
					cmd.b_addr = sum_a[IDX_W-1:0];
					cmd.b_prev = walk_q[IDX_W-1:0];
				end
				state_d = F_PRV;
			end
			F_PRV: begin
				if (walk_q != '0 && SIZE_W'(cur_prev_q) < end_g) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = cur_prev_q;
					other_d     = SIZE_W'(cur_prev_q);
					state_d     = F_PCHK;
				end else begin
					state_d = F_SELF;
				end
			end
			F_PCHK: begin
				if (rd.free) begin
					cmd.a_we   = 1'b1;
					cmd.a_addr = other_q[IDX_W-1:0];
					cmd.a_size = sum_b;
					cmd.a_free = 1'b1;
					nn_d       = other_q + sum_b;
					state_d    = F_PM2;
				end else begin
					state_d = F_SELF;
				end
			end
			F_PM2: begin
				cmd.a_we   = 1'b1;
				cmd.a_addr = walk_q[IDX_W-1:0];
				cmd.b_we   = 1'b1;
				cmd.b_addr = walk_q[IDX_W-1:0];
				state_d    = F_PM3;
			end
			F_PM3: begin
				if (nn_q < end_g) begin
					cmd.b_we   = 1'b1;
					cmd.b_addr = nn_q[IDX_W-1:0];
					cmd.b_prev = other_q[IDX_W-1:0];
				end
				status_d = ST_OK;
				state_d  = S_DONE;
			end
			F_SELF: begin
				cmd.a_we   = 1'b1;
				cmd.a_addr = walk_q[IDX_W-1:0];
				cmd.a_size = cur_size_q;
				cmd.a_free = 1'b1;
				status_d   = ST_OK;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and arena totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			mapped_q <= PG_W'(INIT_PAGES);
			used_q   <= '0;
			tries_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			mapped_q <= mapped_d;
			used_q   <= used_d;
			tries_q  <= tries_d;
		end
	end

	// Working registers of the item in progress.
	always_ff @(posedge clk) begin
		need_q      <= need_d;
		walk_q      <= walk_d;
		last_q      <= last_d;
		last_size_q <= last_size_d;
		last_free_q <= last_free_d;
		cur_size_q  <= cur_size_d;
		cur_prev_q  <= cur_prev_d;
		other_q     <= other_d;
		nn_q        <= nn_d;
		pages_q     <= pages_d;
		status_q    <= status_d;
		addr_q      <= addr_d;
	end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing: top level.
// Holds the configuration registers and the result register; depends on ffha_pkg,
// ffha_store and ffha_ctrl.
//
// Usage: an item on req (valid/stall) is either an allocation of request_bytes or a
// free of block_address. Each item gives exactly one result item on rsp (valid/stall).
// An allocation walks the address-ordered block list in the block store, reading and
// testing one block header at a time, and finishes with a further write when the chosen
// block is split. If nothing fits, the arena grows and the walk runs once more.
// A free checks the block, then merges it with its next and previous blocks when free.
// The block takes the next item in the cycle after a result is handed to the result
// register. The walk, one block header per read, sets the rate.
// After reset the block runs a clearing pass over all 8192 store entries with
// req_stall high; configuration writes are taken during it.
// The arena then holds four pages as one free block.
// The result register lets a new item be accepted while a result waits; if the receiver
// keeps rsp_stall high, the finished item waits inside until the register frees.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written while idle; the block does not check it.
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  req_t            req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rsp_t            rsp,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [PG_W-1:0] cfg_data
);

	logic [PG_W-1:0] limit_q;
	logic [PG_W-1:0] grow_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	logic            idle;
	logic            done;
	logic            res_ready;
	rsp_t            result;
	store_cmd_t      cmd;
	store_rd_t       rd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= PG_W'(MAX_PAGES);
			grow_q  <= PG_W'(INIT_PAGES);
		end else if (cfg_we) begin
			if (cfg_index == CFG_LIMIT) begin
				limit_q <= cfg_data;
			end else begin
				grow_q <= cfg_data;
			end
		end
	end

	assign req_stall = !idle;
	assign res_ready = !rsp_valid_q || !rsp_stall;

	ffha_store u_store (
		.clk (clk),
		.cmd (cmd),
		.rd  (rd)
	);

	ffha_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (req_valid && idle),
		.item        (req),
		.limit_pages (limit_q),
		.grow_pages  (grow_q),
		.res_ready   (res_ready),
		.idle        (idle),
		.done        (done),
		.result      (result),
		.cmd         (cmd),
		.rd          (rd)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only a successful allocation returns an address.
	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.data_address == 16'd0)
		else $error("address returned with a failing status");

	// An accepted item keeps the input stalled until its work is over.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input not stalled after an accepted item");

	// The arena is never empty.
	a_mapped_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.mapped_bytes != 17'd0)
		else $error("mapped arena reported empty");

endmodule
